[hdl/sapq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package sapq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int OCC_W       = 5;

    localparam logic [1:0] REQ_ENQUEUE = 2'd0;
    localparam logic [1:0] REQ_DEQUEUE = 2'd1;
    localparam logic [1:0] REQ_QUERY   = 2'd2;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
    localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [OCC_W-1:0] occ_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] task_id;
        logic [7:0]  task_priority;
    } req_t;

    typedef struct packed {
        logic [15:0] out_task_id;
        logic [7:0]  out_priority;
        logic [1:0]  status;
        occ_t        occupancy;
        logic        is_empty;
    } rsp_t;

    // One stored slot: handle in the upper bits, priority in the lower bits.
    typedef struct packed {
        logic [15:0] task_id;
        logic [7:0]  task_priority;
    } entry_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SHIFT,
        S_DEQ,
        S_RESP
    } state_t;

endpackage

`default_nettype wire

[hdl/sorted_array_priority_queue_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Signals                          Payload
// request   req_valid / req_ready / req      sapq_pkg::req_t
// response  rsp_valid / rsp_ready / rsp      sapq_pkg::rsp_t
//
// An enqueue walks from the rear and moves each lower-priority entry one slot toward the rear,
// one entry at a time, bounded by the one read port of the slot memory.
// A dequeue uses one registered memory read; a query or a refused request goes straight to the response.
// One request is handled at a time.
// Reset clears the indexes and sets the queue empty; the slot memory is not cleared.
// A stalled response holds its register, and no new request is taken until it transfers.

module sorted_array_priority_queue_top (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire sapq_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    output sapq_pkg::rsp_t     rsp
);

    sapq_pkg::state_t state_reg, state_next;
    sapq_pkg::idx_t   front_reg, front_next;
    sapq_pkg::idx_t   rear_reg, rear_next;
    logic             empty_reg, empty_next;
    sapq_pkg::idx_t   pos_reg, pos_next;
    logic [15:0]      id_reg, id_next;
    logic [7:0]       prio_reg, prio_next;
    sapq_pkg::rsp_t   rsp_reg, rsp_next;

    logic             ram_we;
    sapq_pkg::idx_t   ram_waddr;
    sapq_pkg::entry_t ram_wdata;
    sapq_pkg::idx_t   ram_raddr;
    sapq_pkg::entry_t ram_rdata;

    sapq_pkg::idx_t   new_rear;
    logic             overflow;
    logic             shift_go;
    logic             accept;

    localparam sapq_pkg::idx_t LAST_IDX = sapq_pkg::IDX_W'(sapq_pkg::QUEUE_DEPTH - 1);
    localparam sapq_pkg::idx_t ONE_IDX  = sapq_pkg::IDX_W'(1);
    localparam sapq_pkg::idx_t TWO_IDX  = sapq_pkg::IDX_W'(2);

    function automatic sapq_pkg::occ_t occ_of(input logic empty, input sapq_pkg::idx_t front,
                                              input sapq_pkg::idx_t rear);
        logic [sapq_pkg::IDX_W:0] count;
        count = {1'b0, rear} - {1'b0, front} + (sapq_pkg::IDX_W + 1)'(1);
        if (empty)
        begin
            return '0;
        end
        return sapq_pkg::OCC_W'(count);
    endfunction

    sapq_ram #(
        .WIDTH ($bits(sapq_pkg::entry_t)),
        .DEPTH (sapq_pkg::QUEUE_DEPTH)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign accept   = req_valid && req_ready;
    assign new_rear = empty_reg ? '0 : rear_reg + ONE_IDX;
    assign overflow = !empty_reg && (rear_reg == LAST_IDX);
    // The memory holds slot pos-1 this cycle; it moves back while it ranks strictly lower.
    assign shift_go = (pos_reg > front_reg) && (ram_rdata.task_priority < prio_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sapq_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    if (req.req_type == sapq_pkg::REQ_ENQUEUE && !overflow)
                    begin
                        state_next = sapq_pkg::S_SHIFT;
                    end
                    else if (req.req_type == sapq_pkg::REQ_DEQUEUE && !empty_reg)
                    begin
                        state_next = sapq_pkg::S_DEQ;
                    end
                    else
                    begin
                        state_next = sapq_pkg::S_RESP;
                    end
                end
            end
            sapq_pkg::S_SHIFT:
            begin
                if (!shift_go)
                begin
                    state_next = sapq_pkg::S_RESP;
                end
            end
            sapq_pkg::S_DEQ:
            begin
                state_next = sapq_pkg::S_RESP;
            end
            sapq_pkg::S_RESP:
            begin
                if (rsp_ready)
                begin
                    state_next = sapq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = sapq_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        front_next = front_reg;
        rear_next  = rear_reg;
        empty_next = empty_reg;
        pos_next   = pos_reg;
        id_next    = id_reg;
        prio_next  = prio_reg;
        rsp_next   = rsp_reg;
        ram_we     = 1'b0;
        ram_waddr  = pos_reg;
        ram_wdata  = ram_rdata;
        ram_raddr  = front_reg;
        req_ready  = 1'b0;
        rsp_valid  = 1'b0;

        unique case (state_reg)
            sapq_pkg::S_IDLE:
            begin
                req_ready = 1'b1;
                if (req.req_type == sapq_pkg::REQ_ENQUEUE)
                begin
                    ram_raddr = new_rear - ONE_IDX;
                end
                if (accept)
                begin
                    rsp_next.out_task_id  = '0;
                    rsp_next.out_priority = '0;
                    rsp_next.status       = sapq_pkg::STATUS_OK;
                    rsp_next.occupancy    = occ_of(empty_reg, front_reg, rear_reg);
                    rsp_next.is_empty     = empty_reg;
                    if (req.req_type == sapq_pkg::REQ_ENQUEUE)
                    begin
                        if (overflow)
                        begin
                            rsp_next.status = sapq_pkg::STATUS_OVERFLOW;
                        end
                        else
                        begin
                            front_next = empty_reg ? '0 : front_reg;
                            rear_next  = new_rear;
                            empty_next = 1'b0;
                            pos_next   = new_rear;
                            id_next    = req.task_id;
                            prio_next  = req.task_priority;
                        end
                    end
                    else if (req.req_type == sapq_pkg::REQ_DEQUEUE && empty_reg)
                    begin
                        rsp_next.status = sapq_pkg::STATUS_UNDERFLOW;
                    end
                end
            end
            sapq_pkg::S_SHIFT:
            begin
                ram_we = 1'b1;
                if (shift_go)
                begin
                    pos_next  = pos_reg - ONE_IDX;
                    ram_raddr = pos_reg - TWO_IDX;
                end
                else
                begin
                    ram_wdata.task_id       = id_reg;
                    ram_wdata.task_priority = prio_reg;
                    rsp_next.out_task_id    = '0;
                    rsp_next.out_priority   = '0;
                    rsp_next.status         = sapq_pkg::STATUS_OK;
                    rsp_next.occupancy      = occ_of(1'b0, front_reg, rear_reg);
                    rsp_next.is_empty       = 1'b0;
                end
            end
            sapq_pkg::S_DEQ:
            begin
                rsp_next.out_task_id  = ram_rdata.task_id;
                rsp_next.out_priority = ram_rdata.task_priority;
                rsp_next.status       = sapq_pkg::STATUS_OK;
                if (front_reg >= rear_reg)
                begin
                    front_next         = '0;
                    rear_next          = '0;
                    empty_next         = 1'b1;
                    rsp_next.occupancy = '0;
                    rsp_next.is_empty  = 1'b1;
                end
                else
                begin
                    front_next         = front_reg + ONE_IDX;
                    rsp_next.occupancy = occ_of(1'b0, front_reg + ONE_IDX, rear_reg);
                    rsp_next.is_empty  = 1'b0;
                end
            end
            sapq_pkg::S_RESP:
            begin
                rsp_valid = 1'b1;
            end
            default:
            begin
                rsp_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sapq_pkg::S_IDLE;
            front_reg <= '0;
            rear_reg  <= '0;
            empty_reg <= 1'b1;
            pos_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            front_reg <= front_next;
            rear_reg  <= rear_next;
            empty_reg <= empty_next;
            pos_reg   <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg   <= id_next;
        prio_reg <= prio_next;
        rsp_reg  <= rsp_next;
    end

    assign rsp = rsp_reg;

endmodule

`default_nettype wire

[hdl/sapq_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module sapq_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  wire logic                                        clk,
    input  wire logic                                        we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                            wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire
